### src/crm_pkg.sv
package crm_pkg;

  // Register map of the configuration port
  typedef enum logic [2:0] {
    CFG_INPUT_LOW      = 3'd0,
    CFG_INPUT_HIGH     = 3'd1,
    CFG_OUTPUT_START   = 3'd2,
    CFG_OUTPUT_END     = 3'd3,
    CFG_CURVE_EXPONENT = 3'd4
  } cfg_idx_e;

  // Reset values of the registers
  localparam logic signed [15:0] RST_INPUT_LOW      = 16'sd0;
  localparam logic signed [15:0] RST_INPUT_HIGH     = 16'sd1023;
  localparam logic signed [15:0] RST_OUTPUT_START   = 16'sd0;
  localparam logic signed [15:0] RST_OUTPUT_END     = 16'sd255;
  localparam logic [15:0]        RST_CURVE_EXPONENT = 16'd4096;

  // ln(2) and 1.0 in Q30, number of series terms for e^-t
  localparam logic [29:0] LN2_Q30      = 30'd744261118;
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam int          SERIES_TERMS = 12;

  // Special-case flags that ride along with an item
  typedef struct packed {
    logic err;     // empty or reversed input range
    logic p_one;   // power forced to 1.0
    logic p_zero;  // power forced to 0
  } flags_t;

endpackage

### src/curved_range_map.sv
// Throughput: one item per cycle; the pipeline holds as a whole while a valid
// result is stalled at the output, and the input is stalled only then.
// Stage count is set by the bit-per-stage divider, the per-stage squaring
// log2 unit and the two-stage-per-term exp series.
// Reset: asynchronous, active low; clears valid bits and restores the configuration registers.
module curved_range_map #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] mapped_o,
  output logic        range_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import crm_pkg::*;

  localparam int F   = FRACTION_BITS;
  localparam int PW  = F + 1;
  localparam int LZW = $clog2(F + 1);
  localparam int LGW = F + LZW;
  localparam int QW  = LGW + 4;
  localparam int KW  = QW - F;
  localparam int SW  = $clog2(F + 2);
  localparam int VW  = F + 19;
  localparam int NT  = SERIES_TERMS;
  localparam logic [PW-1:0] ONE = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic [29:0]        t;
    logic [SW-1:0]      k;
    flags_t             fl;
    logic signed [31:0] sum;
  } tside_t;

  logic adv;

  // Configuration registers
  logic signed [15:0] in_lo_q, in_hi_q, out_st_q, out_en_q;
  logic [15:0]        ce_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_lo_q  <= RST_INPUT_LOW;
      in_hi_q  <= RST_INPUT_HIGH;
      out_st_q <= RST_OUTPUT_START;
      out_en_q <= RST_OUTPUT_END;
      ce_q     <= RST_CURVE_EXPONENT;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INPUT_LOW:      in_lo_q  <= cfg_data_i;
        CFG_INPUT_HIGH:     in_hi_q  <= cfg_data_i;
        CFG_OUTPUT_START:   out_st_q <= cfg_data_i;
        CFG_OUTPUT_END:     out_en_q <= cfg_data_i;
        CFG_CURVE_EXPONENT: ce_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 0: clamp and form numerator / denominator
  logic signed [15:0] x_c;
  logic signed [16:0] num_w, den_w;

  always_comb begin
    if (sample_i < in_lo_q) x_c = in_lo_q;
    else if (sample_i > in_hi_q) x_c = in_hi_q;
    else x_c = sample_i;
    num_w = {x_c[15], x_c} - {in_lo_q[15], in_lo_q};
    den_w = {in_hi_q[15], in_hi_q} - {in_lo_q[15], in_lo_q};
  end

  logic [15:0] dr_q [0:F+1];
  logic [15:0] dd_q [0:F+1];
  logic [F:0]  dq_q [0:F+1];
  logic        dv_q [0:F+1];
  logic        de_q [0:F+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (adv) dv_q[0] <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dr_q[0] <= num_w[15:0];
      dd_q[0] <= den_w[15:0];
      dq_q[0] <= '0;
      de_q[0] <= (in_lo_q >= in_hi_q);
    end
  end

  // Restoring divider: one quotient bit per stage
  for (genvar j = 0; j <= F; j++) begin : g_div
    logic [16:0] sh;
    logic        ge;
    logic [16:0] diff;

    always_comb begin
      sh   = (j == 0) ? {1'b0, dr_q[j]} : {dr_q[j], 1'b0};
      ge   = (sh >= {1'b0, dd_q[j]});
      diff = sh - {1'b0, dd_q[j]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j+1] <= 1'b0;
      else if (adv) dv_q[j+1] <= dv_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dr_q[j+1] <= ge ? diff[15:0] : sh[15:0];
        dd_q[j+1] <= dd_q[j];
        dq_q[j+1] <= {dq_q[j][F-1:0], ge};
        de_q[j+1] <= de_q[j];
      end
    end
  end

  // Normalize the fraction to [1,2) and classify it
  logic [PW-1:0]  f_w, y_w;
  logic [LZW-1:0] m_w, lz_w;
  flags_t         fl_w;

  always_comb begin
    f_w = dq_q[F+1];
    m_w = '0;
    for (int i = 0; i < F; i++) begin
      if (f_w[i]) m_w = LZW'(i);
    end
    lz_w       = LZW'(F) - m_w;
    y_w        = f_w << lz_w;
    fl_w.err    = de_q[F+1];
    fl_w.p_one  = (ce_q == '0) | f_w[F];
    fl_w.p_zero = (ce_q != '0) & (f_w == '0);
  end

  logic [PW-1:0]  sy_q  [0:F];
  logic [F-1:0]   sb_q  [0:F];
  logic [LZW-1:0] slz_q [0:F];
  flags_t         sfl_q [0:F];
  logic           sv_q  [0:F];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (adv) sv_q[0] <= dv_q[F+1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sy_q[0]  <= y_w;
      sb_q[0]  <= '0;
      slz_q[0] <= lz_w;
      sfl_q[0] <= fl_w;
    end
  end

  // Fraction bits of log2 by repeated squaring, one per stage
  for (genvar i = 0; i < F; i++) begin : g_sq
    logic [2*PW-1:0] sq;
    logic [PW:0]     sh;

    always_comb begin
      sq = sy_q[i] * sy_q[i];
      sh = sq[F+PW:F];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[i+1] <= 1'b0;
      else if (adv) sv_q[i+1] <= sv_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sy_q[i+1]  <= sh[PW] ? sh[PW:1] : sh[PW-1:0];
        sb_q[i+1]  <= {sb_q[i][F-2:0], sh[PW]};
        slz_q[i+1] <= slz_q[i];
        sfl_q[i+1] <= sfl_q[i];
      end
    end
  end

  // Scale -log2(f) by the curve exponent
  logic [LGW-1:0]    lg_w;
  logic [LGW+15:0]   lgp_w;
  logic [QW-1:0]     lq_q;
  flags_t            lfl_q;
  logic              lv_q;

  always_comb begin
    lg_w  = {slz_q[F], {F{1'b0}}} - {{LZW{1'b0}}, sb_q[F]};
    lgp_w = lg_w * ce_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lv_q <= 1'b0;
    else if (adv) lv_q <= sv_q[F];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lq_q  <= lgp_w[LGW+15:12];
      lfl_q <= sfl_q[F];
    end
  end

  // Split q into shift and remainder, form t = r * ln2
  logic [KW-1:0]  k_w;
  logic [F+29:0]  tp_w;
  logic           big_w;
  tside_t         side_w;

  always_comb begin
    k_w          = lq_q[QW-1:F];
    big_w        = (k_w > KW'(F + 1));
    tp_w         = lq_q[F-1:0] * LN2_Q30;
    side_w.t     = tp_w[F+29:F];
    side_w.k     = k_w[SW-1:0];
    side_w.fl    = lfl_q;
    side_w.fl.p_zero = lfl_q.p_zero | (big_w & ~lfl_q.p_one);
    side_w.sum   = $signed({1'b0, Q30_ONE});
  end

  logic [30:0] ta_q  [0:NT];
  tside_t      tsd_q [0:NT];
  logic        tv_q  [0:NT];
  logic [29:0] ma_q  [1:NT];
  tside_t      msd_q [1:NT];
  logic        mv_q  [1:NT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tv_q[0] <= 1'b0;
    else if (adv) tv_q[0] <= lv_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ta_q[0]  <= Q30_ONE;
      tsd_q[0] <= side_w;
    end
  end

  // Series for e^-t: per term one multiply by t, then one divide by n
  for (genvar n = 1; n <= NT; n++) begin : g_term
    localparam int L = $clog2(n);
    localparam longint unsigned RecipM = ((64'd1 << (30 + L)) / n) + 1;
    logic [60:0] pr;
    logic [61:0] pq;
    logic [29:0] na;
    tside_t      nsd;

    always_comb begin
      pr  = ta_q[n-1] * tsd_q[n-1].t;
      pq  = ma_q[n] * RecipM[31:0];
      na  = 30'(pq >> (30 + L));
      nsd = msd_q[n];
      if (n % 2 == 1) nsd.sum = msd_q[n].sum - $signed({2'b00, na});
      else nsd.sum = msd_q[n].sum + $signed({2'b00, na});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[n] <= 1'b0;
        tv_q[n] <= 1'b0;
      end else if (adv) begin
        mv_q[n] <= tv_q[n-1];
        tv_q[n] <= mv_q[n];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ma_q[n]  <= pr[59:30];
        msd_q[n] <= tsd_q[n-1];
        ta_q[n]  <= {1'b0, na};
        tsd_q[n] <= nsd;
      end
    end
  end

  // Clamp the series, shift by k, apply special cases
  logic [30:0]   sc_w;
  logic [PW-1:0] ps_w, pe_w, p_w;
  logic [PW-1:0] pp_q;
  logic          perr_q, pv_q;

  always_comb begin
    if (tsd_q[NT].sum < 0) sc_w = '0;
    else if (tsd_q[NT].sum > $signed({1'b0, Q30_ONE})) sc_w = Q30_ONE;
    else sc_w = tsd_q[NT].sum[30:0];
    ps_w = PW'(sc_w >> (30 - F));
    pe_w = ps_w >> tsd_q[NT].k;
    if (tsd_q[NT].fl.p_one) p_w = ONE;
    else if (tsd_q[NT].fl.p_zero) p_w = '0;
    else p_w = pe_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= 1'b0;
    else if (adv) pv_q <= tv_q[NT];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q   <= p_w;
      perr_q <= tsd_q[NT].fl.err;
    end
  end

  // Scale the power onto the output span
  logic          up_w;
  logic [16:0]   rng_w;
  logic [PW+16:0] mp_q;
  logic          mup_q, merr_q, mvo_q;

  always_comb begin
    up_w  = (out_en_q > out_st_q);
    rng_w = up_w ? 17'({out_en_q[15], out_en_q} - {out_st_q[15], out_st_q})
                 : 17'({out_st_q[15], out_st_q} - {out_en_q[15], out_en_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mvo_q <= 1'b0;
    else if (adv) mvo_q <= pv_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mp_q   <= pp_q * rng_w;
      mup_q  <= up_w;
      merr_q <= perr_q;
    end
  end

  // Add the output start and truncate toward zero
  logic signed [VW-1:0] vs_w, vp_w, v_w, vr_w;
  logic signed [15:0]   mapped_q;
  logic                 err_q, ov_q;

  always_comb begin
    vs_w = VW'(out_st_q) <<< F;
    vp_w = $signed({{(VW-PW-17){1'b0}}, mp_q});
    v_w  = mup_q ? vs_w + vp_w : vs_w - vp_w;
    vr_w = (v_w + (v_w[VW-1] ? $signed(VW'((1 << F) - 1)) : '0)) >>> F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= mvo_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mapped_q <= merr_q ? '0 : vr_w[15:0];
      err_q    <= merr_q;
    end
  end

  // Hold the whole pipeline while the result is stalled
  assign in_stall_o    = ov_q & out_stall_i;
  assign adv           = ~in_stall_o;
  assign out_valid_o   = ov_q;
  assign mapped_o      = mapped_q;
  assign range_error_o = err_q;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> mapped_o == 16'sd0)
    else $error("range error result not zero");

  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

  a_p_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> pp_q <= ONE)
    else $error("power above 1.0");

endmodule
